FILE: rtl/assert_macros.svh
// Shared assertion helpers, sampled on i_clk and idle during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AST_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/plti_pkg.sv
`timescale 1ns / 1ps
package plti_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int POS_W          = 34;   // wrapped position can exceed 32 bits
    localparam int DIV_NUM_W      = 65;
    localparam int DIV_DEN_W      = 33;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        REG_POINT_COUNT   = 2'd0,
        REG_CLOSED_MODE   = 2'd1,
        REG_PERIOD_LENGTH = 2'd2
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRAP,
        ST_COUNT,
        ST_FETCH,
        ST_MUL,
        ST_DIV_VAL,
        ST_DIV_SLOPE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic               en;
        logic [5:0]         idx;
        logic signed [31:0] x;
        logic signed [31:0] y;
    } t_wr;

    typedef struct packed {
        logic signed [31:0] xl;
        logic signed [31:0] yl;
        logic signed [31:0] xh;
        logic signed [31:0] yh;
    } t_cap;

endpackage

FILE: rtl/plti_cell.sv
`timescale 1ns / 1ps
module plti_cell #(
    parameter int IDX = 0,
    parameter int CW  = 7,
    parameter int AW  = 6
) (
    input  logic                             i_clk,
    input  plti_pkg::t_wr                    i_wr,
    input  logic signed [plti_pkg::POS_W-1:0] i_pos,
    input  logic [CW-1:0]                    i_n,
    input  logic [AW-1:0]                    i_lo,
    input  logic [AW-1:0]                    i_hi,
    input  logic [CW-1:0]                    i_cnt,
    output logic [CW-1:0]                    o_cnt,
    input  plti_pkg::t_cap                   i_cap,
    output plti_pkg::t_cap                   o_cap,
    output logic signed [31:0]               o_x
);

    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic [CW-1:0]      r_cnt;
    plti_pkg::t_cap     r_cap;
    logic               w_hit;
    plti_pkg::t_cap     n_cap;

    assign w_hit = (int'(i_n) > IDX) && (plti_pkg::POS_W'(r_x) <= i_pos);

    always_comb begin
        n_cap = i_cap;
        if (int'(i_lo) == IDX) begin
            n_cap.xl = r_x;
            n_cap.yl = r_y;
        end
        if (int'(i_hi) == IDX) begin
            n_cap.xh = r_x;
            n_cap.yh = r_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en && int'(i_wr.idx) == IDX) begin
            r_x <= i_wr.x;
            r_y <= i_wr.y;
        end
        r_cnt <= i_cnt + CW'(w_hit);
        r_cap <= n_cap;
    end

    assign o_cnt = r_cnt;
    assign o_cap = r_cap;
    assign o_x   = r_x;

endmodule

FILE: rtl/plti_div.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module plti_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [plti_pkg::DIV_NUM_W-1:0]   i_num,
    input  logic [plti_pkg::DIV_DEN_W-1:0]   i_den,
    output logic                             o_done,
    output logic [plti_pkg::DIV_NUM_W-1:0]   o_quot,
    output logic [plti_pkg::DIV_DEN_W-1:0]   o_rem
);

    localparam int NW = plti_pkg::DIV_NUM_W;
    localparam int DW = plti_pkg::DIV_DEN_W;
    localparam int KW = $clog2(NW);

    logic          r_busy;
    logic          r_done;
    logic [KW-1:0] r_cnt;
    logic [NW-1:0] r_num;
    logic [DW:0]   r_rem;
    logic [DW-1:0] r_den;
    logic [DW:0]   w_sh;
    logic          w_ge;

    // restoring division, one quotient bit per cycle shifted into r_num
    assign w_sh = {r_rem[DW-1:0], r_num[NW-1]};
    assign w_ge = w_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_cnt <= KW'(NW - 1);
        end else if (r_busy) begin
            r_num <= {r_num[NW-2:0], w_ge};
            r_rem <= w_ge ? (w_sh - {1'b0, r_den}) : w_sh;
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;
    assign o_rem  = r_rem[DW-1:0];

    `AST_IMP(a_start_idle, i_start, !r_busy, "divider restarted while busy")
    `AST_NXT(a_done_single, r_done, !r_done, "divider done held for two cycles")
    `AST_IMP(a_done_not_busy, r_done, !r_busy, "divider done while still busy")

endmodule

FILE: rtl/periodic_linear_table_interpolator.sv
`timescale 1ns / 1ps
// Piecewise linear table in Q16.16. Write beats (op 0) load one breakpoint
// and return nothing; query beats (op 1) return value, slope and a
// saturation flag. Breakpoints live in a row of MAX_POINTS cells; a query
// runs the row twice, once to count breakpoints at or below the position
// and once to pick up the two segment ends. Closed mode first wraps the
// position with a serial divider; after a multiply step the value and the
// slope each take one more division. An open query that clamps to an end
// or lands on a zero-width segment skips the multiply and both divisions
// (a closed query still wraps first), and an empty table goes straight to
// the result. The input stalls until the result beat is taken.
`include "assert_macros.svh"
module periodic_linear_table_interpolator #(
    parameter int MAX_POINTS = plti_pkg::MAX_POINTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_op,
    input  logic [5:0]         i_point_index,
    input  logic signed [31:0] i_position,
    input  logic signed [31:0] i_point_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_value,
    output logic signed [31:0] o_slope,
    output logic               o_slope_saturated,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int AW = $clog2(MAX_POINTS);
    localparam int PW = plti_pkg::POS_W;
    localparam int NW = plti_pkg::DIV_NUM_W;
    localparam int DW = plti_pkg::DIV_DEN_W;

    // configuration
    logic [6:0]  r_point_count;
    logic        r_closed_mode;
    logic [30:0] r_period_length;
    logic [30:0] w_per;

    assign pready = 1'b1;
    assign w_per  = (r_period_length == '0) ? 31'd1 : r_period_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count   <= '0;
            r_closed_mode   <= 1'b0;
            r_period_length <= 31'd65536;
        end else if (psel && penable && pwrite) begin
            unique case (plti_pkg::t_reg_idx'(paddr[3:2]))
                plti_pkg::REG_POINT_COUNT:   r_point_count   <= pwdata[6:0];
                plti_pkg::REG_CLOSED_MODE:   r_closed_mode   <= pwdata[0];
                plti_pkg::REG_PERIOD_LENGTH: r_period_length <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (plti_pkg::t_reg_idx'(paddr[3:2]))
            plti_pkg::REG_POINT_COUNT:   prdata = {25'b0, r_point_count};
            plti_pkg::REG_CLOSED_MODE:   prdata = {31'b0, r_closed_mode};
            plti_pkg::REG_PERIOD_LENGTH: prdata = {1'b0, r_period_length};
            default:                     prdata = '0;
        endcase
    end

    // control
    plti_pkg::t_state r_state, n_state;
    logic             w_in_acc;
    logic             w_query;
    logic             w_write;
    logic [CW-1:0]    w_n;
    logic [CW-1:0]    r_n;
    logic [CW-1:0]    r_timer;
    logic             w_timer_end;
    logic signed [PW-1:0] r_pos;
    logic [AW-1:0]    r_lo, r_hi;
    logic             r_wrap, r_clamp;
    logic             r_dneg;          // sign of the wrap offset, then of dy
    logic [31:0]      r_mag;
    logic [32:0]      r_t;
    logic [DW-1:0]    r_w;
    logic signed [31:0] r_yl;
    logic signed [31:0] r_value, r_slope;
    logic             r_sat;

    assign o_stall     = (r_state != plti_pkg::ST_IDLE);
    assign w_in_acc    = i_valid && !o_stall;
    assign w_query     = w_in_acc && (i_op == plti_pkg::OP_QUERY);
    assign w_write     = w_in_acc && (i_op == plti_pkg::OP_WRITE);
    assign o_valid     = (r_state == plti_pkg::ST_OUT);
    assign w_timer_end = (r_timer == CW'(MAX_POINTS));
    assign w_n = (32'(r_point_count) > 32'(MAX_POINTS)) ? CW'(MAX_POINTS)
                                                         : CW'(r_point_count);

    // cell row
    plti_pkg::t_wr     w_wr;
    logic [CW-1:0]     w_cnt [0:MAX_POINTS];
    plti_pkg::t_cap    w_cap [0:MAX_POINTS];
    logic signed [31:0] w_x0;

    assign w_wr.en  = w_write;
    assign w_wr.idx = i_point_index;
    assign w_wr.x   = i_position;
    assign w_wr.y   = i_point_value;
    assign w_cnt[0] = '0;
    assign w_cap[0] = '0;

    for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
        if (k == 0) begin : g_head
            plti_cell #(.IDX(k), .CW(CW), .AW(AW)) u_cell (
                .i_clk (i_clk),
                .i_wr  (w_wr),
                .i_pos (r_pos),
                .i_n   (r_n),
                .i_lo  (r_lo),
                .i_hi  (r_hi),
                .i_cnt (w_cnt[k]),
                .o_cnt (w_cnt[k+1]),
                .i_cap (w_cap[k]),
                .o_cap (w_cap[k+1]),
                .o_x   (w_x0)
            );
        end else begin : g_body
            plti_cell #(.IDX(k), .CW(CW), .AW(AW)) u_cell (
                .i_clk (i_clk),
                .i_wr  (w_wr),
                .i_pos (r_pos),
                .i_n   (r_n),
                .i_lo  (r_lo),
                .i_hi  (r_hi),
                .i_cnt (w_cnt[k]),
                .o_cnt (w_cnt[k+1]),
                .i_cap (w_cap[k]),
                .o_cap (w_cap[k+1]),
                .o_x   ()
            );
        end
    end

    // divider
    logic          w_div_start;
    logic [NW-1:0] w_div_num;
    logic [DW-1:0] w_div_den;
    logic          w_div_done;
    logic [NW-1:0] w_quot;
    logic [DW-1:0] w_rem;

    plti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot),
        .o_rem   (w_rem)
    );

    // datapath helpers
    logic signed [32:0] w_diff;
    logic [32:0]        w_diff_mag;
    logic [30:0]        w_lx;
    logic [CW-1:0]      w_cnt_last;
    plti_pkg::t_cap     w_cap_last;
    logic signed [34:0] w_seg_w;
    logic signed [34:0] w_seg_t;
    logic signed [32:0] w_dy;
    logic [63:0]        w_pp;
    logic [NW-1:0]      w_prod;
    logic               w_rnd;
    logic [NW-1:0]      w_qr;
    logic               w_div_phase;

    assign w_diff     = 33'(i_position) - 33'(w_x0);
    assign w_diff_mag = w_diff[32] ? 33'(-w_diff) : 33'(w_diff);
    assign w_lx       = (r_dneg && w_rem != '0) ? (w_per - w_rem[30:0]) : w_rem[30:0];
    assign w_cnt_last = w_cnt[MAX_POINTS];
    assign w_cap_last = w_cap[MAX_POINTS];
    assign w_seg_w    = 35'(w_cap_last.xh) + (r_wrap ? 35'(w_per) : 35'd0)
                        - 35'(w_cap_last.xl);
    assign w_seg_t    = 35'(r_pos) - 35'(w_cap_last.xl);
    assign w_dy       = 33'(w_cap_last.yh) - 33'(w_cap_last.yl);
    // |dy| * t with a 33-bit t, built from a 32x32 product
    assign w_pp       = r_mag * r_t[31:0];
    assign w_prod     = NW'(w_pp) + (r_t[32] ? {1'b0, r_mag, 32'b0} : NW'(0));
    assign w_rnd      = {w_rem, 1'b0} >= {1'b0, r_w};
    assign w_qr       = w_quot + NW'(w_rnd);
    assign w_div_phase = (r_state == plti_pkg::ST_WRAP) || (r_state == plti_pkg::ST_DIV_VAL)
                         || (r_state == plti_pkg::ST_DIV_SLOPE);

    always_comb begin
        w_div_start = 1'b0;
        w_div_num   = w_prod;
        w_div_den   = r_w;
        if (w_query && w_n != '0 && r_closed_mode) begin
            w_div_start = 1'b1;
            w_div_num   = NW'(w_diff_mag);
            w_div_den   = DW'(w_per);
        end else if (r_state == plti_pkg::ST_MUL) begin
            w_div_start = 1'b1;
        end else if (r_state == plti_pkg::ST_DIV_VAL && w_div_done) begin
            w_div_start = 1'b1;
            w_div_num   = NW'({r_mag, 16'b0});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= plti_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            plti_pkg::ST_IDLE: begin
                if (w_query) begin
                    if (w_n == '0) begin
                        n_state = plti_pkg::ST_OUT;
                    end else if (r_closed_mode) begin
                        n_state = plti_pkg::ST_WRAP;
                    end else begin
                        n_state = plti_pkg::ST_COUNT;
                    end
                end
            end
            plti_pkg::ST_WRAP: begin
                if (w_div_done) n_state = plti_pkg::ST_COUNT;
            end
            plti_pkg::ST_COUNT: begin
                if (w_timer_end) n_state = plti_pkg::ST_FETCH;
            end
            plti_pkg::ST_FETCH: begin
                if (w_timer_end) begin
                    if (r_clamp || w_seg_w <= 0) begin
                        n_state = plti_pkg::ST_OUT;
                    end else begin
                        n_state = plti_pkg::ST_MUL;
                    end
                end
            end
            plti_pkg::ST_MUL:       n_state = plti_pkg::ST_DIV_VAL;
            plti_pkg::ST_DIV_VAL: begin
                if (w_div_done) n_state = plti_pkg::ST_DIV_SLOPE;
            end
            plti_pkg::ST_DIV_SLOPE: begin
                if (w_div_done) n_state = plti_pkg::ST_OUT;
            end
            plti_pkg::ST_OUT: begin
                if (!i_stall) n_state = plti_pkg::ST_IDLE;
            end
            default: n_state = plti_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (n_state != r_state) begin
            r_timer <= '0;
        end else begin
            r_timer <= r_timer + 1'b1;
        end

        unique case (r_state)
            plti_pkg::ST_IDLE: begin
                if (w_query) begin
                    r_n     <= w_n;
                    r_pos   <= PW'(i_position);
                    r_dneg  <= w_diff[32];
                    r_value <= '0;
                    r_slope <= '0;
                    r_sat   <= 1'b0;
                end
            end
            plti_pkg::ST_WRAP: begin
                if (w_div_done) r_pos <= PW'(w_x0) + PW'(w_lx);
            end
            plti_pkg::ST_COUNT: begin
                if (w_timer_end) begin
                    if (w_cnt_last == '0 || w_cnt_last >= r_n) begin
                        r_wrap  <= r_closed_mode;
                        r_clamp <= !r_closed_mode;
                        r_lo    <= (w_cnt_last == '0 && !r_closed_mode) ? '0
                                                                       : AW'(r_n - 1'b1);
                        r_hi    <= '0;
                    end else begin
                        r_wrap  <= 1'b0;
                        r_clamp <= 1'b0;
                        r_lo    <= AW'(w_cnt_last - 1'b1);
                        r_hi    <= AW'(w_cnt_last);
                    end
                end
            end
            plti_pkg::ST_FETCH: begin
                if (w_timer_end) begin
                    r_value <= w_cap_last.yl;
                    r_slope <= '0;
                    r_sat   <= !r_clamp && w_seg_w <= 0;
                    r_yl    <= w_cap_last.yl;
                    r_w     <= DW'(w_seg_w);
                    r_dneg  <= w_dy[32];
                    r_mag   <= w_dy[32] ? 32'(-w_dy) : 32'(w_dy);
                    // t only leaves [0, w] with an unsorted table
                    if (w_seg_t < 0) begin
                        r_t <= '0;
                    end else if (w_seg_t > w_seg_w) begin
                        r_t <= 33'(w_seg_w);
                    end else begin
                        r_t <= 33'(w_seg_t);
                    end
                end
            end
            plti_pkg::ST_DIV_VAL: begin
                if (w_div_done) begin
                    r_value <= r_dneg ? 32'(34'(r_yl) - 34'(w_qr[32:0]))
                                      : 32'(34'(r_yl) + 34'(w_qr[32:0]));
                end
            end
            plti_pkg::ST_DIV_SLOPE: begin
                if (w_div_done) begin
                    if (r_dneg) begin
                        if (w_qr > NW'(33'h0_8000_0000)) begin
                            r_slope <= 32'sh8000_0000;
                            r_sat   <= 1'b1;
                        end else begin
                            r_slope <= 32'(-w_qr[31:0]);
                        end
                    end else begin
                        if (w_qr > NW'(32'h7FFF_FFFF)) begin
                            r_slope <= 32'sh7FFF_FFFF;
                            r_sat   <= 1'b1;
                        end else begin
                            r_slope <= w_qr[31:0];
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_value           = r_value;
    assign o_slope           = r_slope;
    assign o_slope_saturated = r_sat;

    `AST_IMP(a_div_done_expected, w_div_done, w_div_phase, "divider finished outside a divide step")
    `AST_NXT(a_one_beat, o_valid && !i_stall, !o_valid, "result beat repeated")
    `AST_NXT(a_write_silent, w_write, !o_valid, "write beat produced a result")

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
module tb;

    localparam int NPTS       = 64;
    localparam int ITEM_GOAL  = 1150;
    localparam int SETTLE     = 400;    // longer than one closed-mode query
    localparam int WDOG_LIMIT = 20000;

    typedef struct {
        logic signed [31:0] value;
        logic signed [31:0] slope;
        logic               sat;
    } t_interp;

    logic               i_clk, i_rst_n;
    logic               i_valid, o_stall, i_op;
    logic [5:0]         i_point_index;
    logic signed [31:0] i_position, i_point_value;
    logic               o_valid, i_stall;
    logic signed [31:0] o_value, o_slope;
    logic               o_slope_saturated;
    logic               psel, penable, pwrite, pready;
    logic [3:0]         paddr;
    logic [31:0]        pwdata, prdata;

    periodic_linear_table_interpolator dut (.*);

    // shadow of the table and registers
    longint  tbl_x [NPTS];
    longint  tbl_y [NPTS];
    longint  sh_count, sh_closed, sh_period;
    t_interp pending_interp[$];
    int      fails, items_sent, wdog;
    bit      stall_long;

    always begin
        i_clk = 1'b0; #4;
        i_clk = 1'b1; #4;
    end

    function automatic longint div_nearest(logic [127:0] num, logic [127:0] den);
        logic [127:0] q, r;
        q = num / den;
        r = num % den;
        if (2 * r >= den) q = q + 1;
        return longint'(q);
    endfunction

    function automatic void predict_query(longint pos);
        t_interp e;
        longint n, per, lx, x, cnt, lo, hi, xl, xh, yl, yh, w, t, dy, mag, q, sm, val;
        bit wrap;
        e = '{0, 0, 1'b0};
        n = sh_count > NPTS ? NPTS : sh_count;
        per = sh_period == 0 ? 1 : sh_period;
        wrap = 0;
        if (n == 0) begin
            pending_interp.push_back(e);
            return;
        end
        x = pos;
        if (sh_closed != 0) begin
            lx = (x - tbl_x[0]) % per;
            if (lx < 0) lx += per;
            x = tbl_x[0] + lx;
        end
        cnt = 0;
        for (int i = 0; i < n; i++) if (tbl_x[i] <= x) cnt++;
        if (cnt == 0 || cnt >= n) begin
            if (sh_closed == 0) begin
                e.value = 32'(tbl_y[cnt == 0 ? 0 : n - 1]);
                pending_interp.push_back(e);
                return;
            end
            wrap = 1; lo = n - 1; hi = 0;
        end else begin
            lo = cnt - 1; hi = cnt;
        end
        xl = tbl_x[lo];
        xh = tbl_x[hi] + (wrap ? per : 0);
        yl = tbl_y[lo];
        yh = tbl_y[hi];
        w = xh - xl;
        if (w <= 0) begin
            e.value = 32'(yl);
            e.sat = 1'b1;
            pending_interp.push_back(e);
            return;
        end
        t = x - xl;
        if (t < 0) t = 0;
        if (t > w) t = w;
        dy = yh - yl;
        mag = dy < 0 ? -dy : dy;
        q = div_nearest(128'(mag) * 128'(t), 128'(w));
        val = dy < 0 ? yl - q : yl + q;
        sm = div_nearest(128'(mag) << 16, 128'(w));
        if (dy < 0) begin
            if (sm > 64'h8000_0000) begin sm = 64'h8000_0000; e.sat = 1'b1; end
            e.slope = 32'(-sm);
        end else begin
            if (sm > 64'h7FFF_FFFF) begin sm = 64'h7FFF_FFFF; e.sat = 1'b1; end
            e.slope = 32'(sm);
        end
        e.value = 32'(val);
        pending_interp.push_back(e);
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side: stall and compare
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (pending_interp.size() == 0) begin
                    $display("%0t unexpected result value %h slope %h", $time, o_value, o_slope);
                    fails++;
                end else begin
                    t_interp e;
                    e = pending_interp.pop_front();
                    if (o_value !== e.value) begin
                        $display("%0t value exp %h got %h", $time, e.value, o_value);
                        fails++;
                    end
                    if (o_slope !== e.slope) begin
                        $display("%0t slope exp %h got %h", $time, e.slope, o_slope);
                        fails++;
                    end
                    if (o_slope_saturated !== e.sat) begin
                        $display("%0t slope_saturated exp %b got %b", $time, e.sat,
                                 o_slope_saturated);
                        fails++;
                    end
                end
            end
            if (stall_long) i_stall <= ($urandom_range(0, 99) < 70);
            else            i_stall <= ($urandom_range(0, 99) < 20);
            if ($urandom_range(0, 199) == 0) stall_long <= ~stall_long;
        end
    end

    // watchdog on cycles with no beat moving
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || psel || !i_rst_n)
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    task automatic send_beat(logic op, logic [5:0] idx, longint pos, longint val);
        i_valid       <= 1'b1;
        i_op          <= op;
        i_point_index <= idx;
        i_position    <= 32'(pos);
        i_point_value <= 32'(val);
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
        if (op == plti_pkg::OP_WRITE) begin
            tbl_x[idx] = longint'(signed'(32'(pos)));
            tbl_y[idx] = longint'(signed'(32'(val)));
        end else begin
            predict_query(longint'(signed'(32'(pos))));
        end
        begin
            int g;
            g = gap_len();
            if (g > 0) begin
                i_valid <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_interp.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic apb_write(plti_pkg::t_reg_idx r, longint val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 4'(4 * int'(r));
        pwdata  <= 32'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (r)
            plti_pkg::REG_POINT_COUNT:   sh_count  = val & 64'h7F;
            plti_pkg::REG_CLOSED_MODE:   sh_closed = val & 64'h1;
            plti_pkg::REG_PERIOD_LENGTH: sh_period = val & 64'h7FFF_FFFF;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_config(longint cnt, longint closed, longint per);
        wait_drained();
        apb_write(plti_pkg::REG_POINT_COUNT, cnt);
        apb_write(plti_pkg::REG_CLOSED_MODE, closed);
        apb_write(plti_pkg::REG_PERIOD_LENGTH, per);
    endtask

    // strictly increasing x with random spacing, or junk order when sorted is 0
    task automatic load_table(int n, bit sorted);
        longint step_max, x, span;
        longint steps[NPTS];
        case ($urandom_range(0, 2))
            0: step_max = 16;
            1: step_max = 65536;
            default: step_max = 64'hFFFF_FFFF / NPTS;
        endcase
        span = 0;
        for (int i = 1; i < n; i++) begin
            steps[i] = $urandom_range(1, 32'(step_max));
            span += steps[i];
        end
        x = -64'sh8000_0000 + longint'($urandom_range(0, 32'(64'hFFFF_FFFF - span)));
        for (int i = 0; i < n; i++) begin
            longint y, px;
            if (i > 0) x += steps[i];
            px = x;
            if (!sorted) begin
                if ($urandom_range(0, 1)) px = longint'(signed'($urandom()));
                else if (i > 0) px = tbl_x[i - 1];
            end
            case ($urandom_range(0, 5))
                0: y = 64'sh7FFF_FFFF;
                1: y = -64'sh8000_0000;
                2: y = 0;
                default: y = longint'(signed'($urandom()));
            endcase
            send_beat(plti_pkg::OP_WRITE, 6'(i), px, y);
        end
    endtask

    task automatic query_some(int k);
        longint n, p;
        n = sh_count > NPTS ? NPTS : sh_count;
        for (int j = 0; j < k; j++) begin
            int m;
            m = n > 0 ? $urandom_range(0, 32'(n - 1)) : 0;
            case ($urandom_range(0, 5))
                0: p = tbl_x[m];
                1: p = tbl_x[m] + $urandom_range(0, 65535);
                2: p = tbl_x[m] - $urandom_range(1, 65535);
                3: p = $urandom_range(0, 1) ? 64'sh7FFF_FFFF : -64'sh8000_0000;
                default: p = longint'(signed'($urandom()));
            endcase
            if (p > 64'sh7FFF_FFFF) p = 64'sh7FFF_FFFF;
            if (p < -64'sh8000_0000) p = -64'sh8000_0000;
            send_beat(plti_pkg::OP_QUERY, 6'($urandom()), p, longint'(signed'($urandom())));
        end
    endtask

    task automatic test_empty_table();
        send_beat(plti_pkg::OP_QUERY, 6'd0, 0, 0);
        send_beat(plti_pkg::OP_QUERY, 6'd63, 64'sh7FFF_FFFF, -1);
        send_beat(plti_pkg::OP_QUERY, 6'd0, -64'sh8000_0000, 64'sh7FFF_FFFF);
    endtask

    // extremes: unit-width jump between rails, open and closed, one point,
    // unsorted table with a zero-width segment
    task automatic test_directed();
        send_beat(plti_pkg::OP_WRITE, 6'd0, -64'sh8000_0000, -64'sh8000_0000);
        send_beat(plti_pkg::OP_WRITE, 6'd1, -64'sh7FFF_FFFF, 64'sh7FFF_FFFF);
        send_beat(plti_pkg::OP_WRITE, 6'd2, 0, 0);
        send_beat(plti_pkg::OP_WRITE, 6'd3, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF);
        set_config(4, 0, 65536);
        send_beat(plti_pkg::OP_QUERY, 6'd0, -64'sh8000_0000, 0);
        send_beat(plti_pkg::OP_QUERY, 6'd0, -64'sh7FFF_FFFF, 0);
        send_beat(plti_pkg::OP_QUERY, 6'd0, -12345, 0);
        send_beat(plti_pkg::OP_QUERY, 6'd0, 64'sh7FFF_FFFF, 0);
        send_beat(plti_pkg::OP_QUERY, 6'd0, 64'sh4000_0001, 0);
        set_config(4, 1, 64'h7FFF_FFFF);
        send_beat(plti_pkg::OP_QUERY, 6'd0, 64'sh7FFF_FFFF, 0);
        send_beat(plti_pkg::OP_QUERY, 6'd0, -5, 0);
        set_config(1, 1, 1);
        send_beat(plti_pkg::OP_QUERY, 6'd0, 77, 0);
        send_beat(plti_pkg::OP_WRITE, 6'd1, -64'sh8000_0000, 5);
        set_config(3, 0, 65536);
        send_beat(plti_pkg::OP_QUERY, 6'd0, 100, 0);
        send_beat(plti_pkg::OP_QUERY, 6'd0, -64'sh8000_0000, 0);
    endtask

    task automatic test_random();
        for (int i = 0; i < NPTS; i++)
            send_beat(plti_pkg::OP_WRITE, 6'(i), i * 65536, i);
        while (items_sent < ITEM_GOAL) begin
            int n, r;
            longint per;
            r = $urandom_range(0, 19);
            n = r == 0 ? NPTS : (r == 1 ? 127 : $urandom_range(1, 8));
            if (r == 2) n = 0;
            set_config(n, $urandom_range(0, 1), 1);
            load_table(n > NPTS ? NPTS : n, $urandom_range(0, 9) != 0);
            r = $urandom_range(0, 9);
            if (r == 0)      per = 1;
            else if (r == 1) per = 64'h7FFF_FFFF;
            else if (r == 2) per = $urandom_range(1, 32'h7FFF_FFFF);
            else begin
                longint nn;
                nn = n > NPTS ? NPTS : (n == 0 ? 1 : n);
                per = tbl_x[nn - 1] - tbl_x[0] + $urandom_range(1, 1 << 20);
                if (per < 1 || per > 64'h7FFF_FFFF) per = 64'h7FFF_FFFF;
            end
            set_config(n, sh_closed, per);
            query_some($urandom_range(4, 16));
            if ($urandom_range(0, 3) == 0)
                send_beat(plti_pkg::OP_WRITE,
                          6'($urandom_range(0, n > NPTS ? NPTS - 1 : 7)),
                          longint'(signed'($urandom())), longint'(signed'($urandom())));
            query_some($urandom_range(1, 4));
        end
    endtask

    initial begin
        items_sent = 0;
        sh_count = 0; sh_closed = 0; sh_period = 65536;
        i_rst_n <= 1'b0; i_valid <= 1'b0; i_op <= plti_pkg::OP_WRITE; i_point_index <= '0;
        i_position <= '0; i_point_value <= '0;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_table();
        test_directed();
        test_random();
        wait_drained();
        if (fails == 0) $display("tb: PASS");
        else            $display("tb: FAIL");
        $finish;
    end
endmodule
